// File: rtl/core/amdc_pkg.sv
package amdc_pkg;

    localparam int LVL_W    = 4;
    localparam int DLT_W    = 7;
    localparam int EXT_W    = 16;
    localparam int SMP_W    = 8;
    localparam int FILL_W   = 12;

    // mixer datapath widths
    localparam int BASE_W   = 8;    // p1 + p2 + tri + 4*noise + delta <= 232
    localparam int HALF_W   = 15;   // rounded half of |extra| <= 16384
    localparam int MIXED_W  = 17;   // signed sum of base and half extra
    localparam int MAG_W    = 15;   // |mixed| <= 16616
    localparam int NUM_W    = 23;   // |mixed| * 255 + 560
    localparam int QUO_W    = 18;   // numerator / 32
    localparam int SMAG_W   = 12;   // scaled magnitude <= 3783
    localparam int MIXO_W   = 13;   // signed scaled mix, -3730 .. 255

    // scale by 255/1120: (mag*255 + 560) >> 5, then divide by 35 by reciprocal
    localparam logic [NUM_W-1:0] SCALE_BIAS = NUM_W'(560);
    localparam int SCALE_PRE_SH = 5;
    localparam int RECIP_W      = 19;
    localparam logic [RECIP_W-1:0] RECIP_35 = RECIP_W'(479350);
    localparam int RECIP_SH     = 24;
    localparam int PROD_W       = QUO_W + RECIP_W;

    // dc tracker, Q8 estimate, 1/64 step
    localparam int EST_W    = 24;
    localparam int EST_FRAC = 8;
    localparam int DC_SH    = 6;
    localparam int CTR_W    = 18;

    localparam logic [SMP_W-1:0] MID_SAMPLE  = SMP_W'(128);
    localparam logic [SMP_W-1:0] SAMPLE_CEIL = SMP_W'(255);
    localparam logic [SMP_W-1:0] ZERO_SAMPLE = SMP_W'(0);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [LVL_W-1:0]        pulse_one;
        logic [LVL_W-1:0]        pulse_two;
        logic [LVL_W-1:0]        triangle_level;
        logic [LVL_W-1:0]        noise_level;
        logic [DLT_W-1:0]        delta_level;
        logic signed [EXT_W-1:0] extra_sample;
        logic                    extra_valid;
    } req_t;

    typedef struct packed {
        op_t                      op;
        logic signed [MIXO_W-1:0] mix;
    } mix_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } ring_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_sts_t;

endpackage

// File: rtl/core/amdc_mix.sv
module amdc_mix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  amdc_pkg::req_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output amdc_pkg::mix_t  out_item
);

    localparam int NSTG = 6;

    typedef struct packed {
        amdc_pkg::op_t                     op;
        logic [amdc_pkg::BASE_W-1:0]       base;
        logic signed [amdc_pkg::EXT_W-1:0] extra;
    } s2_t;

    typedef struct packed {
        amdc_pkg::op_t              op;
        logic                       neg;
        logic [amdc_pkg::MAG_W-1:0] mag;
    } s3_t;

    typedef struct packed {
        amdc_pkg::op_t              op;
        logic                       neg;
        logic [amdc_pkg::QUO_W-1:0] quo;
    } s4_t;

    typedef struct packed {
        amdc_pkg::op_t               op;
        logic                        neg;
        logic [amdc_pkg::SMAG_W-1:0] smag;
    } s5_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    amdc_pkg::req_t s1_reg;
    s2_t            s2_reg, s2_next;
    s3_t            s3_reg, s3_next;
    s4_t            s4_reg, s4_next;
    s5_t            s5_reg, s5_next;
    amdc_pkg::mix_t s6_reg, s6_next;

    logic [amdc_pkg::EXT_W-1:0]   ext_raw;
    logic [amdc_pkg::EXT_W-1:0]   ext_mag;
    logic [amdc_pkg::HALF_W-1:0]  ext_half;
    logic [amdc_pkg::EXT_W-1:0]   half_ext;
    logic [amdc_pkg::MIXED_W-1:0] mixed;
    logic [amdc_pkg::MIXED_W-1:0] mixed_abs;
    logic [amdc_pkg::NUM_W-1:0]   num;
    logic [amdc_pkg::PROD_W-1:0]  prod;
    logic [amdc_pkg::MIXO_W-1:0]  smag_x;

    // ready ripples back from the output through empty stages
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_item  = s6_reg;

    // stage 2: base sum and rounded half of the extra sample
    always_comb
    begin
        ext_raw  = s1_reg.extra_sample;
        ext_mag  = ext_raw[amdc_pkg::EXT_W-1] ? (~ext_raw + amdc_pkg::EXT_W'(1)) : ext_raw;
        ext_half = amdc_pkg::HALF_W'(((amdc_pkg::EXT_W+1)'(ext_mag)
                   + (amdc_pkg::EXT_W+1)'(1)) >> 1);
        half_ext = {1'b0, ext_half};
        s2_next.op = s1_reg.op;
        s2_next.base = amdc_pkg::BASE_W'(s1_reg.pulse_one)
                     + amdc_pkg::BASE_W'(s1_reg.pulse_two)
                     + amdc_pkg::BASE_W'(s1_reg.triangle_level)
                     + {2'b00, s1_reg.noise_level, 2'b00}
                     + {1'b0, s1_reg.delta_level};
        if (!s1_reg.extra_valid)
        begin
            s2_next.extra = '0;
        end
        else if (ext_raw[amdc_pkg::EXT_W-1])
        begin
            s2_next.extra = $signed(~half_ext + amdc_pkg::EXT_W'(1));
        end
        else
        begin
            s2_next.extra = $signed(half_ext);
        end
    end

    // stage 3: signed mix and its magnitude
    always_comb
    begin
        mixed = $signed({{(amdc_pkg::MIXED_W-amdc_pkg::BASE_W){1'b0}}, s2_reg.base})
              + $signed({s2_reg.extra[amdc_pkg::EXT_W-1], s2_reg.extra});
        mixed_abs = mixed[amdc_pkg::MIXED_W-1] ? (~mixed + amdc_pkg::MIXED_W'(1)) : mixed;
        s3_next.op  = s2_reg.op;
        s3_next.neg = mixed[amdc_pkg::MIXED_W-1];
        s3_next.mag = mixed_abs[amdc_pkg::MAG_W-1:0];
    end

    // stage 4: mag*255 + 560, then drop the power-of-two part of 1120
    always_comb
    begin
        num = {s3_reg.mag, 8'b0}
            - amdc_pkg::NUM_W'(s3_reg.mag)
            + amdc_pkg::SCALE_BIAS;
        s4_next.op  = s3_reg.op;
        s4_next.neg = s3_reg.neg;
        s4_next.quo = num[amdc_pkg::SCALE_PRE_SH +: amdc_pkg::QUO_W];
    end

    // stage 5: divide by 35 through the reciprocal
    always_comb
    begin
        prod = amdc_pkg::PROD_W'(s4_reg.quo) * amdc_pkg::PROD_W'(amdc_pkg::RECIP_35);
        s5_next.op   = s4_reg.op;
        s5_next.neg  = s4_reg.neg;
        s5_next.smag = prod[amdc_pkg::RECIP_SH +: amdc_pkg::SMAG_W];
    end

    // stage 6: restore sign, clamp above only
    always_comb
    begin
        smag_x = amdc_pkg::MIXO_W'(s5_reg.smag);
        s6_next.op = s5_reg.op;
        if (s5_reg.neg)
        begin
            s6_next.mix = $signed(~smag_x + amdc_pkg::MIXO_W'(1));
        end
        else if (s5_reg.smag > amdc_pkg::SMAG_W'(amdc_pkg::SAMPLE_CEIL))
        begin
            s6_next.mix = $signed(amdc_pkg::MIXO_W'(amdc_pkg::SAMPLE_CEIL));
        end
        else
        begin
            s6_next.mix = $signed(smag_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            s1_reg <= in_item;
        end
        if (rdy[1])
        begin
            s2_reg <= s2_next;
        end
        if (rdy[2])
        begin
            s3_reg <= s3_next;
        end
        if (rdy[3])
        begin
            s4_reg <= s4_next;
        end
        if (rdy[4])
        begin
            s5_reg <= s5_next;
        end
        if (rdy[5])
        begin
            s6_reg <= s6_next;
        end
    end

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("mixer output changed while held");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg == '0 |-> in_ready)
        else $error("empty mixer pipeline refused a request");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted request missing from first stage");
`endif

endmodule

// File: rtl/core/amdc_dc.sv
module amdc_dc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                upd,
    input  logic signed [amdc_pkg::MIXO_W-1:0]  mix,
    output logic [amdc_pkg::SMP_W-1:0]          sample
);

    logic signed [amdc_pkg::EST_W-1:0]                    est_reg, est_next;
    logic signed [amdc_pkg::EST_W:0]                      diff;
    logic signed [amdc_pkg::EST_W-1:0]                    step;
    logic signed [amdc_pkg::EST_W-amdc_pkg::EST_FRAC-1:0] est_int;
    logic signed [amdc_pkg::CTR_W-1:0]                    ctr;

    always_comb
    begin
        diff = (amdc_pkg::EST_W+1)'($signed({mix, {amdc_pkg::EST_FRAC{1'b0}}}))
             - (amdc_pkg::EST_W+1)'(est_reg);
        step     = amdc_pkg::EST_W'(diff >>> amdc_pkg::DC_SH);
        est_next = est_reg + step;
        // floor of the Q8 estimate
        est_int  = $signed(est_next[amdc_pkg::EST_W-1:amdc_pkg::EST_FRAC]);
        ctr = $signed(amdc_pkg::CTR_W'(amdc_pkg::MID_SAMPLE))
            + amdc_pkg::CTR_W'(mix)
            - amdc_pkg::CTR_W'(est_int);
        if (ctr < 0)
        begin
            sample = amdc_pkg::ZERO_SAMPLE;
        end
        else if (ctr > $signed(amdc_pkg::CTR_W'(amdc_pkg::SAMPLE_CEIL)))
        begin
            sample = amdc_pkg::SAMPLE_CEIL;
        end
        else
        begin
            sample = ctr[amdc_pkg::SMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
        end
        else if (upd)
        begin
            est_reg <= est_next;
        end
    end

endmodule

// File: rtl/core/amdc_ring.sv
module amdc_ring #(
    parameter int DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  amdc_pkg::ring_cmd_t           cmd,
    input  logic [amdc_pkg::SMP_W-1:0]    wdata,
    output amdc_pkg::ring_sts_t           sts,
    output logic [amdc_pkg::FILL_W-1:0]   fill,
    output logic [amdc_pkg::SMP_W-1:0]    rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int DW = PW + 1;

    logic [amdc_pkg::SMP_W-1:0] ring_mem [DEPTH];
    logic [amdc_pkg::SMP_W-1:0] rdata_reg;

    logic [PW-1:0] wp_reg, wp_next, wp_inc;
    logic [PW-1:0] rp_reg, rp_next, rp_inc;
    logic [DW-1:0] wx, rx, cnt;

    always_comb
    begin
        wp_inc = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        rp_inc = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        sts.empty = (wp_reg == rp_reg);
        sts.full  = (wp_inc == rp_reg);   // one slot kept free
        wp_next = cmd.wr ? wp_inc : wp_reg;
        rp_next = cmd.rd ? rp_inc : rp_reg;
        // occupancy after this request
        wx = DW'(wp_next);
        rx = DW'(rp_next);
        cnt = (wx >= rx) ? (wx - rx) : (wx + DW'(DEPTH) - rx);
        fill = amdc_pkg::FILL_W'(cnt[PW-1:0]);
    end

    assign rdata = rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            ring_mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= ring_mem[rp_reg];
        end
    end

`ifndef ASSERT_OFF
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> !sts.full)
        else $error("ring written while full");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> !sts.empty)
        else $error("ring read while empty");

    a_read_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> rp_reg != $past(rp_reg))
        else $error("read pointer did not move after a read");
`endif

endmodule

// File: rtl/core/audio_mix_dc_track_sample_fifo.sv
// channel   dir  handshake              payload
// config    in   cfg_write              cfg_data (paused)
// request   in   req_valid / req_stall  operation, pulse_one, pulse_two, triangle_level,
//                                       noise_level, delta_level, extra_sample, extra_valid
// result    out  res_valid / res_stall  sample_out, accepted, fill_level
//
// one request per cycle sustained while res_stall is low, one result per request;
// on its way to the result a request passes six mixer stages and the result register
// the dc estimate is updated from its own register; the ring memory takes one write
// or one read per cycle and its read data lands in the result cycle
// reset clears pointers, dc estimate and paused; ring contents are not cleared
// res_stall holds the result and backs up through the pipeline to req_stall
module audio_mix_dc_track_sample_fifo #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                operation,
    input  logic [amdc_pkg::LVL_W-1:0]          pulse_one,
    input  logic [amdc_pkg::LVL_W-1:0]          pulse_two,
    input  logic [amdc_pkg::LVL_W-1:0]          triangle_level,
    input  logic [amdc_pkg::LVL_W-1:0]          noise_level,
    input  logic [amdc_pkg::DLT_W-1:0]          delta_level,
    input  logic signed [amdc_pkg::EXT_W-1:0]   extra_sample,
    input  logic                                extra_valid,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [amdc_pkg::SMP_W-1:0]          sample_out,
    output logic                                accepted,
    output logic [amdc_pkg::FILL_W-1:0]         fill_level
);

    logic                paused_reg;
    amdc_pkg::req_t      req_item;
    logic                mix_ready;
    logic                mix_vld;
    amdc_pkg::mix_t      mix_item;
    logic                res_rdy;
    logic                fire;
    logic                is_push;
    amdc_pkg::ring_cmd_t ring_cmd;
    amdc_pkg::ring_sts_t ring_sts;
    logic [amdc_pkg::FILL_W-1:0] ring_fill;
    logic [amdc_pkg::SMP_W-1:0]  ring_rdata;
    logic [amdc_pkg::SMP_W-1:0]  dc_sample;

    logic                        res_vld_reg;
    logic                        res_pop_reg, res_pop_next;
    logic                        res_acc_reg, res_acc_next;
    logic [amdc_pkg::SMP_W-1:0]  res_smp_reg, res_smp_next;
    logic [amdc_pkg::FILL_W-1:0] res_fill_reg, res_fill_next;

    always_comb
    begin
        req_item.op             = amdc_pkg::op_t'(operation);
        req_item.pulse_one      = pulse_one;
        req_item.pulse_two      = pulse_two;
        req_item.triangle_level = triangle_level;
        req_item.noise_level    = noise_level;
        req_item.delta_level    = delta_level;
        req_item.extra_sample   = extra_sample;
        req_item.extra_valid    = extra_valid;
    end

    assign req_stall = !mix_ready;

    amdc_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (mix_ready),
        .in_item   (req_item),
        .out_valid (mix_vld),
        .out_ready (res_rdy),
        .out_item  (mix_item)
    );

    // ring and tracker act when the mixed request moves into the result register
    assign res_rdy = !res_vld_reg || !res_stall;
    assign fire    = mix_vld && res_rdy;
    assign is_push = (mix_item.op == amdc_pkg::OP_PUSH);

    always_comb
    begin
        ring_cmd.wr = fire && is_push && !paused_reg && !ring_sts.full;
        ring_cmd.rd = fire && !is_push && !ring_sts.empty;
    end

    amdc_dc u_dc (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (fire && is_push && !paused_reg),
        .mix    (mix_item.mix),
        .sample (dc_sample)
    );

    amdc_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .wdata (dc_sample),
        .sts   (ring_sts),
        .fill  (ring_fill),
        .rdata (ring_rdata)
    );

    always_comb
    begin
        res_fill_next = ring_fill;
        case (mix_item.op)
            amdc_pkg::OP_PUSH:
            begin
                res_pop_next = 1'b0;
                if (paused_reg)
                begin
                    res_smp_next = amdc_pkg::ZERO_SAMPLE;
                    res_acc_next = 1'b0;
                end
                else
                begin
                    res_smp_next = dc_sample;
                    res_acc_next = !ring_sts.full;
                end
            end
            amdc_pkg::OP_POP:
            begin
                res_pop_next = 1'b1;
                res_smp_next = amdc_pkg::MID_SAMPLE;
                res_acc_next = !ring_sts.empty;
            end
            default:
            begin
                res_pop_next = 1'b0;
                res_smp_next = amdc_pkg::ZERO_SAMPLE;
                res_acc_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                paused_reg <= cfg_data;
            end
            if (res_rdy)
            begin
                res_vld_reg <= mix_vld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_pop_reg  <= res_pop_next;
            res_acc_reg  <= res_acc_next;
            res_smp_reg  <= res_smp_next;
            res_fill_reg <= res_fill_next;
        end
    end

    // a pop that found data takes the ring read data, registered in the same edge
    assign res_valid  = res_vld_reg;
    assign sample_out = (res_pop_reg && res_acc_reg) ? ring_rdata : res_smp_reg;
    assign accepted   = res_acc_reg;
    assign fill_level = res_fill_reg;

endmodule

// File: tb/audio_mix_dc_track_sample_fifo_tb.sv
module audio_mix_dc_track_sample_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 4096;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [amdc_pkg::SMP_W-1:0]  sample;
        logic                        accepted;
        logic [amdc_pkg::FILL_W-1:0] fill;
    } mix_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_write = 1'b0;
    logic                              cfg_data = 1'b0;
    logic                              req_valid = 1'b0;
    logic                              req_stall;
    logic                              operation = 1'b0;
    logic [amdc_pkg::LVL_W-1:0]        pulse_one = '0;
    logic [amdc_pkg::LVL_W-1:0]        pulse_two = '0;
    logic [amdc_pkg::LVL_W-1:0]        triangle_level = '0;
    logic [amdc_pkg::LVL_W-1:0]        noise_level = '0;
    logic [amdc_pkg::DLT_W-1:0]        delta_level = '0;
    logic signed [amdc_pkg::EXT_W-1:0] extra_sample = '0;
    logic                              extra_valid = 1'b0;
    logic                              res_valid;
    logic                              res_stall = 1'b0;
    logic [amdc_pkg::SMP_W-1:0]        sample_out;
    logic                              accepted;
    logic [amdc_pkg::FILL_W-1:0]       fill_level;

    amdc_pkg::req_t request_q[$];
    mix_result_t    expected_samples[$];
    amdc_pkg::req_t offered = '0;
    idle_mode_t     idle_mode = IDLE_NONE;
    bit             hold_ask = 1'b0;
    bit             hold_taken = 1'b0;
    int             hold_left = 0;
    int             quiet = 0;
    int             mismatches = 0;

    // shadow of the block state
    logic [amdc_pkg::SMP_W-1:0] ring_copy [RING_DEPTH];
    int unsigned                wr_idx = 0;
    int unsigned                rd_idx = 0;
    int                         dc_q8 = 0;
    bit                         paused_now = 1'b0;

    audio_mix_dc_track_sample_fifo #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .operation      (operation),
        .pulse_one      (pulse_one),
        .pulse_two      (pulse_two),
        .triangle_level (triangle_level),
        .noise_level    (noise_level),
        .delta_level    (delta_level),
        .extra_sample   (extra_sample),
        .extra_valid    (extra_valid),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .sample_out     (sample_out),
        .accepted       (accepted),
        .fill_level     (fill_level)
    );

    always #1ns clk = ~clk;

    function automatic mix_result_t predict_sample(amdc_pkg::req_t r);
        mix_result_t res;
        int raw;
        int extra;
        int half;
        int mixed;
        int mag;
        int smag;
        int mix;
        int o;
        int unsigned nxt;
        res = '0;
        if (r.op == amdc_pkg::OP_POP)
        begin
            if (rd_idx != wr_idx)
            begin
                res.sample = ring_copy[rd_idx];
                rd_idx = (rd_idx + 1) % RING_DEPTH;
                res.accepted = 1'b1;
            end
            else
                res.sample = amdc_pkg::MID_SAMPLE;
        end
        else if (!paused_now)
        begin
            extra = 0;
            if (r.extra_valid)
            begin
                raw = $signed(r.extra_sample);
                // half of the magnitude, rounded up, sign put back after
                half = ((raw < 0 ? -raw : raw) + 1) / 2;
                extra = raw < 0 ? -half : half;
            end
            mixed = int'(r.pulse_one) + int'(r.pulse_two) + int'(r.triangle_level)
                  + 4 * int'(r.noise_level) + int'(r.delta_level) + extra;
            mag = mixed < 0 ? -mixed : mixed;
            smag = (mag * 255 + 560) / 1120;
            mix = mixed < 0 ? -smag : smag;
            if (mix > 255)
                mix = 255;
            // floor shifts on the signed estimate
            dc_q8 += (mix * 256 - dc_q8) >>> 6;
            o = 128 + mix - (dc_q8 >>> 8);
            if (o > 255)
                o = 255;
            if (o < 0)
                o = 0;
            res.sample = amdc_pkg::SMP_W'(o);
            nxt = (wr_idx + 1) % RING_DEPTH;
            if (nxt != rd_idx)
            begin
                ring_copy[wr_idx] = res.sample;
                wr_idx = nxt;
                res.accepted = 1'b1;
            end
        end
        res.fill = amdc_pkg::FILL_W'((wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH);
        return res;
    endfunction

    function automatic amdc_pkg::req_t make_item(amdc_pkg::op_t op, int p1, int p2, int tl,
                                                 int nz, int dl, int ex, bit ev);
        amdc_pkg::req_t r;
        r.op = op;
        r.pulse_one = amdc_pkg::LVL_W'(p1);
        r.pulse_two = amdc_pkg::LVL_W'(p2);
        r.triangle_level = amdc_pkg::LVL_W'(tl);
        r.noise_level = amdc_pkg::LVL_W'(nz);
        r.delta_level = amdc_pkg::DLT_W'(dl);
        r.extra_sample = amdc_pkg::EXT_W'(ex);
        r.extra_valid = ev;
        return r;
    endfunction

    function automatic amdc_pkg::req_t random_item(int unsigned pop_pct);
        int ex;
        // half the extra samples stay small so the mix wanders around zero
        if ($urandom_range(1) != 0)
            ex = int'($urandom_range(65535));
        else
            ex = int'($urandom_range(700)) - 350;
        return make_item(($urandom_range(99) < pop_pct) ? amdc_pkg::OP_POP : amdc_pkg::OP_PUSH,
                         $urandom_range(15), $urandom_range(15), $urandom_range(15),
                         $urandom_range(15), $urandom_range(127), ex,
                         1'($urandom_range(1)));
    endfunction

    function automatic bit chance(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int unsigned send_gap_pct(idle_mode_t m);
        case (m)
            IDLE_SEND: return 86;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct(idle_mode_t m);
        case (m)
            IDLE_RECV: return 86;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                expected_samples.push_back(predict_sample(offered));
            if (!req_valid || !req_stall)
            begin
                if (request_q.size() != 0 && !chance(send_gap_pct(idle_mode)))
                begin
                    offered = request_q.pop_front();
                    req_valid <= 1'b1;
                    operation <= offered.op;
                    pulse_one <= offered.pulse_one;
                    pulse_two <= offered.pulse_two;
                    triangle_level <= offered.triangle_level;
                    noise_level <= offered.noise_level;
                    delta_level <= offered.delta_level;
                    extra_sample <= offered.extra_sample;
                    extra_valid <= offered.extra_valid;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_ask && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        mix_result_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected result sample %0d accepted %0d fill %0d",
                             $time, sample_out, accepted, fill_level);
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $display("%0t: sample_out expected %0d got %0d",
                                 $time, want.sample, sample_out);
                        mismatches++;
                    end
                    if (accepted !== want.accepted)
                    begin
                        $display("%0t: accepted expected %0d got %0d",
                                 $time, want.accepted, accepted);
                        mismatches++;
                    end
                    if (fill_level !== want.fill)
                    begin
                        $display("%0t: fill_level expected %0d got %0d",
                                 $time, want.fill, fill_level);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
                res_stall <= 1'b1;
            else
                res_stall <= chance(recv_stall_pct(idle_mode));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic settle();
        while (request_q.size() != 0 || req_valid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_paused(bit v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        paused_now = v;
        @(negedge clk);
    endtask

    task automatic queue_random(int n, int unsigned pop_pct);
        repeat (n) request_q.push_back(random_item(pop_pct));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_paused(1'b0);

        // extremes and rounding corners
        request_q.push_back(make_item(amdc_pkg::OP_POP, 0, 0, 0, 0, 0, 0, 0));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, 0, 0));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 15, 15, 15, 15, 127, 0, 0));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, 32767, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, -32768, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, -1, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, 1, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, -3, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, 2, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 15, 15, 15, 15, 127, -1, 0));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 15, 15, 15, 15, 127, -32768, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 15, 15, 15, 15, 127, 32767, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 0, 0, 0, 0, 0, -465, 1));
        request_q.push_back(make_item(amdc_pkg::OP_PUSH, 5, 10, 3, 8, 64, 200, 1));
        repeat (5) request_q.push_back(make_item(amdc_pkg::OP_POP, 15, 15, 15, 15, 127, -1, 1));
        settle();

        queue_random(250, 45);
        settle();

        // pushes ignored while paused, pops still drain
        set_paused(1'b1);
        idle_mode = IDLE_SEND;
        queue_random(120, 50);
        settle();

        set_paused(1'b0);
        idle_mode = IDLE_RECV;
        queue_random(300, 45);
        settle();

        // long receiver hold while requests keep coming
        idle_mode = IDLE_NONE;
        hold_ask = 1'b1;
        queue_random(250, 40);
        settle();

        // pile up samples, then push while paused
        queue_random(400, 0);
        settle();
        set_paused(1'b1);
        queue_random(20, 0);
        settle();

        // pops only, draining the piled-up samples
        set_paused(1'b0);
        idle_mode = IDLE_BOTH;
        queue_random(450, 100);
        settle();

        queue_random(100, 50);
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
